// ===== src/civil_date_difference_macros.svh =====
// Assertion macros for the civil date difference block.
// Used by the checker; expects clk and rst_n in scope.
`ifndef CIVIL_DATE_DIFFERENCE_MACROS_SVH
`define CIVIL_DATE_DIFFERENCE_MACROS_SVH

// same-cycle implication
`define CDD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdd same-cycle check failed");

// next-cycle implication
`define CDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdd next-cycle check failed");

`endif

// ===== src/cdd_pkg.sv =====
// Constants, tables and types for the civil date difference pipeline.
// No dependencies.
package cdd_pkg;

    localparam logic [17:0] YEAR_BIAS    = 18'd40000;
    localparam logic [14:0] DIV25_MULT   = 15'd20972;
    localparam int          DIV25_SHIFT  = 19;
    localparam logic [24:0] DAYS_IN_YEAR = 25'd365;
    localparam logic [16:0] CENTURY      = 17'd100;
    localparam logic [16:0] QUAD_CENTURY = 17'd400;
    localparam logic [16:0] REM100_LAST  = 17'd99;
    localparam logic [16:0] REM400_LAST  = 17'd399;

    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  LEAP_FEB_LEN = 5'd29;

    // days from March 1 to the first of the month, month shifted to start in March
    localparam logic [8:0] MONTH_OFFSET [16] = '{
        9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
    };

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    typedef struct packed {
        logic after;
        logic earlier;
        logic equal;
    } cmp_t;

endpackage

// ===== src/civil_date_difference.sv =====
// Civil date difference: four-stage pipeline, two date lanes.
// Depends on cdd_pkg.
//
//  channel  handshake                  payload
//  item     item_valid / item_stall    first_/second_ day, month, year
//  result   result_valid / result_stall day_difference, valid, compare flags
//
// One item per cycle while the result is not stalled; the result passes through the stage registers s1 to s4.
// Each date lane: bias and day of year, multiply, divide-by-100 and sum, subtract.
// Reset clears the stage valid bits only.
// A stalled result holds; earlier stages keep filling empty slots.
module civil_date_difference
    import cdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [4:0]         first_day,
    input  logic [3:0]         first_month,
    input  logic signed [15:0] first_year,
    input  logic [4:0]         second_day,
    input  logic [3:0]         second_month,
    input  logic signed [15:0] second_year,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [25:0] day_difference,
    output logic               first_valid,
    output logic               second_valid,
    output logic               first_after,
    output logic               first_before,
    output logic               dates_equal
);

    logic adv1, adv2, adv3, adv4;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    logic [4:0]  in_day  [2];
    logic [3:0]  in_month[2];
    logic [15:0] in_year [2];
    logic [17:0] biased  [2];
    cmp_t        cmp_next;

    logic [16:0] s1_year_reg [2];
    logic [8:0]  s1_doy_reg  [2];
    logic [3:0]  s1_month_reg[2];
    logic [4:0]  s1_day_reg  [2];
    cmp_t        s1_cmp_reg;

    logic [29:0] s2_prod_reg [2];
    logic [24:0] s2_tri_reg  [2];
    logic [16:0] s2_year_reg [2];
    logic [8:0]  s2_doy_reg  [2];
    logic [3:0]  s2_month_reg[2];
    logic [4:0]  s2_day_reg  [2];
    cmp_t        s2_cmp_reg;

    logic [10:0] hund        [2];
    logic [25:0] dn_next     [2];
    logic [16:0] rem100      [2];
    logic [16:0] rem400      [2];
    logic        leap        [2];
    logic [4:0]  dim         [2];
    logic        ok_next     [2];

    logic [25:0] s3_dn_reg   [2];
    logic        s3_ok_reg   [2];
    cmp_t        s3_cmp_reg;

    logic [25:0] s4_diff_reg;
    logic        s4_ok_reg   [2];
    cmp_t        s4_cmp_reg;

    assign adv4       = !s4_valid_reg || !result_stall;
    assign adv3       = !s3_valid_reg || adv4;
    assign adv2       = !s2_valid_reg || adv3;
    assign adv1       = !s1_valid_reg || adv2;
    assign item_stall = !adv1;

    always_comb
    begin
        in_day[0]   = first_day;
        in_month[0] = first_month;
        in_year[0]  = first_year;
        in_day[1]   = second_day;
        in_month[1] = second_month;
        in_year[1]  = second_year;
        for (int i = 0; i < 2; i++)
        begin
            biased[i] = {{2{in_year[i][15]}}, in_year[i]} + YEAR_BIAS
                        - {17'd0, (in_month[i] <= MONTH_FEB)};
        end
        if (first_year != second_year)
        begin
            cmp_next.after   = first_year > second_year;
            cmp_next.earlier = first_year < second_year;
        end
        else if (first_month != second_month)
        begin
            cmp_next.after   = first_month > second_month;
            cmp_next.earlier = first_month < second_month;
        end
        else
        begin
            cmp_next.after   = first_day > second_day;
            cmp_next.earlier = first_day < second_day;
        end
        cmp_next.equal = (first_day == second_day) && (first_month == second_month)
                         && (first_year == second_year);
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            hund[i]    = s2_prod_reg[i][DIV25_SHIFT +: 11];
            dn_next[i] = {1'b0, s2_tri_reg[i]} + {11'd0, s2_year_reg[i][16:2]}
                         - {15'd0, hund[i]} + {17'd0, hund[i][10:2]}
                         + {17'd0, s2_doy_reg[i]};
            rem100[i]  = s2_year_reg[i] - 17'({6'd0, hund[i]} * CENTURY);
            rem400[i]  = s2_year_reg[i] - 17'({8'd0, hund[i][10:2]} * QUAD_CENTURY);
            leap[i]    = (s2_year_reg[i][1:0] == 2'b11 && rem100[i] != REM100_LAST)
                         || rem400[i] == REM400_LAST;
            dim[i]     = MONTH_LEN[s2_month_reg[i]];
            if (s2_month_reg[i] == MONTH_FEB && leap[i])
            begin
                dim[i] = LEAP_FEB_LEN;
            end
            ok_next[i] = (s2_month_reg[i] inside {[MONTH_JAN:MONTH_DEC]})
                         && s2_day_reg[i] != 5'd0 && s2_day_reg[i] <= dim[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= item_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s1_year_reg[i]  <= biased[i][16:0];
                s1_doy_reg[i]   <= MONTH_OFFSET[in_month[i]] + {4'd0, in_day[i]};
                s1_month_reg[i] <= in_month[i];
                s1_day_reg[i]   <= in_day[i];
            end
            s1_cmp_reg <= cmp_next;
        end
        if (adv2)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s2_prod_reg[i]  <= {15'd0, s1_year_reg[i][16:2]} * {15'd0, DIV25_MULT};
                s2_tri_reg[i]   <= {8'd0, s1_year_reg[i]} * DAYS_IN_YEAR;
                s2_year_reg[i]  <= s1_year_reg[i];
                s2_doy_reg[i]   <= s1_doy_reg[i];
                s2_month_reg[i] <= s1_month_reg[i];
                s2_day_reg[i]   <= s1_day_reg[i];
            end
            s2_cmp_reg <= s1_cmp_reg;
        end
        if (adv3)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s3_dn_reg[i] <= dn_next[i];
                s3_ok_reg[i] <= ok_next[i];
            end
            s3_cmp_reg <= s2_cmp_reg;
        end
        if (adv4)
        begin
            s4_diff_reg  <= s3_dn_reg[0] - s3_dn_reg[1];
            s4_ok_reg[0] <= s3_ok_reg[0];
            s4_ok_reg[1] <= s3_ok_reg[1];
            s4_cmp_reg   <= s3_cmp_reg;
        end
    end

    assign result_valid   = s4_valid_reg;
    assign day_difference = s4_diff_reg;
    assign first_valid    = s4_ok_reg[0];
    assign second_valid   = s4_ok_reg[1];
    assign first_after    = s4_cmp_reg.after;
    assign first_before   = s4_cmp_reg.earlier;
    assign dates_equal    = s4_cmp_reg.equal;

endmodule

// ===== src/cdd_checker.sv =====
// Port-level checks for civil_date_difference, attached by bind.
// Depends on civil_date_difference_macros.svh.
`include "civil_date_difference_macros.svh"

module cdd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [25:0] day_difference,
    input logic               first_valid,
    input logic               second_valid,
    input logic               first_after,
    input logic               first_before,
    input logic               dates_equal
);

    `CDD_ASSERT_NEXT(result_hold_a, result_valid && result_stall,
        result_valid && $stable(day_difference) && $stable(dates_equal))
    `CDD_ASSERT_NOW(equal_zero_a, result_valid && dates_equal,
        day_difference == 26'sd0 && !first_after && !first_before)
    `CDD_ASSERT_NOW(after_sign_a, result_valid && first_valid && second_valid && first_after,
        day_difference > 26'sd0)
    `CDD_ASSERT_NOW(before_sign_a, result_valid && first_valid && second_valid && first_before,
        day_difference < 26'sd0)

endmodule

bind civil_date_difference cdd_checker u_cdd_checker (.*);
